// ===== src/pidfd_pkg.sv =====
// Shared types and constants for the filtered-derivative PID step.
// No dependencies; imported by the top level and the control-law datapath.
`default_nettype none

package pidfd_pkg;

  localparam int SAMPLE_W = 16;            // width of samples and coefficients
  localparam int ERR_W    = SAMPLE_W + 1;  // setpoint minus measurement
  localparam int P_W      = 33;            // kp * error, 8 fraction bits
  localparam int INTEG_W  = 24;            // clamped integrator, 8 fraction bits
  localparam int DERIV_W  = 32;            // derivative accumulator, 8 fraction bits
  localparam int ADDR_W   = 3;             // configuration register index

  // Configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_KP_GAIN     = 3'd0,
    REG_KI_HALF_DT  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DERIV_DECAY = 3'd3,
    REG_INTEG_MAX   = 3'd4,
    REG_INTEG_MIN   = 3'd5
  } reg_idx_t;

  // Coefficient set seen by the datapath
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] kp_gain;      // Q8.8
    logic signed [SAMPLE_W-1:0] ki_half_dt;   // Q8.8
    logic signed [SAMPLE_W-1:0] deriv_gain;   // Q8.8
    logic signed [SAMPLE_W-1:0] deriv_decay;  // Q1.15
    logic signed [SAMPLE_W-1:0] integ_max;    // sample units
    logic signed [SAMPLE_W-1:0] integ_min;    // sample units
  } pidfd_cfg_t;

endpackage

`default_nettype wire

// ===== src/pidfd_calc.sv =====
// Control-law datapath: proportional term, clamped trapezoidal integrator and
// filtered derivative on the measurement, with the controller state. Uses pidfd_pkg.
`default_nettype none

module pidfd_calc
  import pidfd_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          step,         // item moves into the state stage
  input  wire logic signed [SAMPLE_W-1:0] setpoint,
  input  wire logic signed [SAMPLE_W-1:0] measurement,
  input  wire pidfd_cfg_t              cfg,
  output logic signed [P_W-1:0]        p_term_r,
  output logic signed [INTEG_W-1:0]    integ_acc_r,
  output logic signed [DERIV_W-1:0]    deriv_acc_r,
  output logic                         integ_clamped_r
);

  localparam logic signed [33:0] DSUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] DSUM_MIN = -34'sd2147483648;

  logic signed [ERR_W-1:0]    last_error_r;
  logic signed [SAMPLE_W-1:0] last_measure_r;

  logic signed [ERR_W-1:0]    err;
  logic signed [P_W-1:0]      p_term_nxt;
  logic signed [17:0]         err_sum;
  logic signed [33:0]         integ_inc;
  logic signed [34:0]         integ_sum;
  logic signed [INTEG_W-1:0]  integ_hi;
  logic signed [INTEG_W-1:0]  integ_lo;
  logic signed [INTEG_W-1:0]  integ_acc_nxt;
  logic                       integ_clamped_nxt;
  logic signed [47:0]         decay_prod;
  logic signed [47:0]         decay_rnd;
  logic signed [32:0]         decay_term;
  logic signed [ERR_W-1:0]    meas_delta;
  logic signed [32:0]         gain_prod;
  logic signed [33:0]         deriv_sum;
  logic signed [DERIV_W-1:0]  deriv_acc_nxt;

  // Error and proportional term
  assign err        = ERR_W'(setpoint) - ERR_W'(measurement);
  assign p_term_nxt = P_W'(cfg.kp_gain) * P_W'(err);

  // Trapezoidal integrator with limits, upper limit checked first
  assign err_sum   = 18'(err) + 18'(last_error_r);
  assign integ_inc = 34'(cfg.ki_half_dt) * 34'(err_sum);
  assign integ_sum = 35'(integ_acc_r) + 35'(integ_inc);
  assign integ_hi  = {cfg.integ_max, 8'h00};
  assign integ_lo  = {cfg.integ_min, 8'h00};

  always_comb begin
    integ_clamped_nxt = 1'b1;
    if (integ_sum > 35'(integ_hi)) begin
      integ_acc_nxt = integ_hi;
    end else if (integ_sum < 35'(integ_lo)) begin
      integ_acc_nxt = integ_lo;
    end else begin
      integ_acc_nxt     = integ_sum[INTEG_W-1:0];
      integ_clamped_nxt = 1'b0;
    end
  end

  // Filtered derivative: rounded decay of the old value minus gain * delta
  assign decay_prod = 48'(cfg.deriv_decay) * 48'(deriv_acc_r);
  assign decay_rnd  = decay_prod + 48'sd16384;
  assign decay_term = decay_rnd[47:15];
  assign meas_delta = ERR_W'(measurement) - ERR_W'(last_measure_r);
  assign gain_prod  = 33'(cfg.deriv_gain) * 33'(meas_delta);
  assign deriv_sum  = 34'(decay_term) - 34'(gain_prod);

  always_comb begin
    if (deriv_sum > DSUM_MAX) begin
      deriv_acc_nxt = DERIV_W'(DSUM_MAX);
    end else if (deriv_sum < DSUM_MIN) begin
      deriv_acc_nxt = DERIV_W'(DSUM_MIN);
    end else begin
      deriv_acc_nxt = deriv_sum[DERIV_W-1:0];
    end
  end

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r   <= '0;
      last_measure_r <= '0;
      integ_acc_r    <= '0;
      deriv_acc_r    <= '0;
    end else if (step) begin
      last_error_r   <= err;
      last_measure_r <= measurement;
      integ_acc_r    <= integ_acc_nxt;
      deriv_acc_r    <= deriv_acc_nxt;
    end
  end

  // Per-item terms that travel with the state into the output stage
  always_ff @(posedge clk) begin
    if (step) begin
      p_term_r        <= p_term_nxt;
      integ_clamped_r <= integ_clamped_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/pid_filtered_derivative_step_top.sv =====
// PID step with clamped trapezoidal integrator and filtered derivative on the measurement.
// Top level: stream handshake, configuration registers, output rounding. Uses pidfd_pkg, pidfd_calc.
//
// One request in, one result out, three register stages (input, state, output). The
// request is registered in the input stage, then the state stage, and its result is held
// in the output register until taken. One request can be taken every cycle while the
// output is not stalled. The rate is set by the state stage: the derivative recurrence
// (16x32 multiply, round, subtract, saturate) closes on itself through the state
// registers. Each stage loads whenever the stage after it is empty or moving, so while
// a result waits at the output, requests keep entering until the input and state stages
// both hold one. Configuration is written through cfg_we/cfg_addr/cfg_wdata; writes to
// unused indexes are dropped. Coefficients should only change while idle.
`default_nettype none

module pid_filtered_derivative_step_top
  import pidfd_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  // request stream
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [31:0]         in_tdata,    // [15:0] setpoint, [31:16] measurement
  // result stream
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [23:0]         out_tdata,   // [15:0] control_out, [16] integ_clamped,
                                           // [17] out_saturated, [23:18] zero
  // configuration writes
  input  wire                 cfg_we,
  input  wire  [ADDR_W-1:0]   cfg_addr,
  input  wire  [SAMPLE_W-1:0] cfg_wdata
);

  pidfd_cfg_t cfg_r;

  logic                       a_valid_r, b_valid_r, c_valid_r;
  logic                       ld_a, ld_b, ld_c;
  logic signed [SAMPLE_W-1:0] setpoint_r, measurement_r;

  logic signed [P_W-1:0]      p_term;
  logic signed [INTEG_W-1:0]  integ_acc;
  logic signed [DERIV_W-1:0]  deriv_acc;
  logic                       integ_clamped;

  logic signed [34:0]         drive;
  logic signed [26:0]         drive_smp;
  logic signed [SAMPLE_W-1:0] control_nxt;
  logic                       sat_nxt;

  logic signed [SAMPLE_W-1:0] control_out_r;
  logic                       integ_clamped_r;
  logic                       out_saturated_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain     <= '0;
      cfg_r.ki_half_dt  <= '0;
      cfg_r.deriv_gain  <= '0;
      cfg_r.deriv_decay <= '0;
      cfg_r.integ_max   <= 16'sh7FFF;
      cfg_r.integ_min   <= 16'sh8000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KP_GAIN:     cfg_r.kp_gain     <= cfg_wdata;
        REG_KI_HALF_DT:  cfg_r.ki_half_dt  <= cfg_wdata;
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_wdata;
        REG_DERIV_DECAY: cfg_r.deriv_decay <= cfg_wdata;
        REG_INTEG_MAX:   cfg_r.integ_max   <= cfg_wdata;
        REG_INTEG_MIN:   cfg_r.integ_min   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage loads when it is empty or its contents move on
  assign ld_c       = !c_valid_r || out_tready;
  assign ld_b       = !b_valid_r || ld_c;
  assign ld_a       = !a_valid_r || ld_b;
  assign in_tready  = ld_a;
  assign out_tvalid = c_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (ld_a) a_valid_r <= in_tvalid;
      if (ld_b) b_valid_r <= a_valid_r;
      if (ld_c) c_valid_r <= b_valid_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_tvalid && ld_a) begin
      setpoint_r    <= in_tdata[15:0];
      measurement_r <= in_tdata[31:16];
    end
  end

  // Control law and state
  pidfd_calc u_calc (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (a_valid_r && ld_b),
    .setpoint        (setpoint_r),
    .measurement     (measurement_r),
    .cfg             (cfg_r),
    .p_term_r        (p_term),
    .integ_acc_r     (integ_acc),
    .deriv_acc_r     (deriv_acc),
    .integ_clamped_r (integ_clamped)
  );

  // Drive: sum, round half up to a sample, saturate to 16 bits
  assign drive     = 35'(p_term) + 35'(integ_acc) + 35'(deriv_acc) + 35'sd128;
  assign drive_smp = drive[34:8];

  always_comb begin
    sat_nxt = 1'b1;
    if (drive_smp > 27'sd32767) begin
      control_nxt = 16'sh7FFF;
    end else if (drive_smp < -27'sd32768) begin
      control_nxt = 16'sh8000;
    end else begin
      control_nxt = drive_smp[SAMPLE_W-1:0];
      sat_nxt     = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (b_valid_r && ld_c) begin
      control_out_r   <= control_nxt;
      integ_clamped_r <= integ_clamped;
      out_saturated_r <= sat_nxt;
    end
  end

  assign out_tdata = {6'b0, out_saturated_r, integ_clamped_r, control_out_r};

endmodule

`default_nettype wire

// ===== src/pidfd_chk.sv =====
// Port-level checks for the PID step top level, attached with bind.
// Depends on pid_filtered_derivative_step_top port names.
`default_nettype none

module pidfd_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an empty output never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // saturation flag only on a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |->
      (out_tdata[15:0] == 16'h7FFF) || (out_tdata[15:0] == 16'h8000))
    else $error("saturation flag without rail value");

endmodule

bind pid_filtered_derivative_step_top pidfd_chk u_pidfd_chk (.*);

`default_nettype wire
